### rtl/core/crpn_pkg.sv
// shared codes and tables for the complex rpn stack evaluator
// no dependencies; used by complex_rpn_stack_evaluator_unit in rtl/core
package crpn_pkg;

  localparam logic [3:0] MODE_PUSH = 4'd0;
  localparam logic [3:0] MODE_ADD  = 4'd1;
  localparam logic [3:0] MODE_SUB  = 4'd2;
  localparam logic [3:0] MODE_MUL  = 4'd3;
  localparam logic [3:0] MODE_DIV  = 4'd4;
  localparam logic [3:0] MODE_POW  = 4'd5;
  localparam logic [3:0] MODE_ARG  = 4'd6;
  localparam logic [3:0] MODE_CONJ = 4'd7;
  localparam logic [3:0] MODE_MOD  = 4'd8;

  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_EXPC  = 3'd4;
  localparam logic [2:0] ST_SAT   = 3'd5;

  // product-sum terms run on the shared multiplier
  typedef enum logic [2:0] {
    T_DEN, T_MRE, T_MIM, T_DRE, T_DIM, T_MOD
  } term_t;

  localparam logic signed [33:0] HALF_PI_Q30 = 34'sd1686629713;

  // cordic angle table, atan(2^-i) in q30
  function automatic logic [29:0] atan_q30(input logic [4:0] i);
    logic [29:0] v;
    case (i)
      5'd0:  v = 30'd843314857;
      5'd1:  v = 30'd497837829;
      5'd2:  v = 30'd263043837;
      5'd3:  v = 30'd133525159;
      5'd4:  v = 30'd67021687;
      5'd5:  v = 30'd33543516;
      5'd6:  v = 30'd16775851;
      5'd7:  v = 30'd8388437;
      5'd8:  v = 30'd4194283;
      5'd9:  v = 30'd2097149;
      5'd10: v = 30'd1048576;
      5'd11: v = 30'd524288;
      5'd12: v = 30'd262144;
      5'd13: v = 30'd131072;
      5'd14: v = 30'd65536;
      5'd15: v = 30'd32768;
      5'd16: v = 30'd16384;
      5'd17: v = 30'd8192;
      5'd18: v = 30'd4096;
      5'd19: v = 30'd2048;
      5'd20: v = 30'd1024;
      5'd21: v = 30'd512;
      5'd22: v = 30'd256;
      5'd23: v = 30'd128;
      5'd24: v = 30'd64;
      5'd25: v = 30'd32;
      5'd26: v = 30'd16;
      5'd27: v = 30'd8;
      5'd28: v = 30'd4;
      5'd29: v = 30'd2;
      default: v = 30'd0;
    endcase
    return v;
  endfunction

endpackage

### rtl/core/crpn_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module crpn_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/complex_rpn_stack_evaluator_unit.sv
// complex rpn stack evaluator top level: sequencer, shared multiplier, divider, sqrt, cordic
// depends on crpn_pkg and crpn_ram
//
// Takes one postfix token per input beat and returns one beat with the stack top, depth and
// status. The operand stack lives in a ram; the top entry is also held in registers, so a
// two-operand token reads the ram once. Work runs on one 32x32 multiplier, a one-bit-per-cycle
// divider/square root and a 30-step cordic, and the block takes no new beat while a token is
// in progress. Power repeats a complex multiply, or a divide for a negative exponent, n times;
// n is the real exponent's magnitude rounded up and capped at MAX_POWER. A complex exponent or a
// negative power of zero ends early, as do divide by zero and the argument of zero. The cordic
// pre-scale doubles the vector while it is small. Each token also needs the output register to
// be free.
module complex_rpn_stack_evaluator_unit #(
  parameter int STACK_DEPTH = 16,
  parameter int FRAC_BITS   = 16,
  parameter int MAX_POWER   = 255
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // operand_real, operand_imag
  input  logic [4:0]  s_tuser,   // mode[3:0], first
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // top_real, top_imag, depth, zero pad
  output logic [2:0]  m_tuser    // status
);

  localparam int AW  = $clog2(STACK_DEPTH);
  localparam int CW  = $clog2(STACK_DEPTH + 1);
  localparam int PW  = $clog2(MAX_POWER + 1);
  localparam int ASH = 30 - FRAC_BITS;
  localparam logic signed [31:0] ONE_Q  = 32'(1) << FRAC_BITS;
  localparam logic signed [45:0] LIM40  = 46'sd1 <<< 40;
  localparam logic [32:0]        NROUND = (33'd1 << FRAC_BITS) - 33'd1;

  typedef enum logic [13:0] {
    S_IDLE = 14'b00000000000001,
    S_RDA  = 14'b00000000000010,
    S_EXEC = 14'b00000000000100,
    S_PROD = 14'b00000000001000,
    S_MFIN = 14'b00000000010000,
    S_DPRE = 14'b00000000100000,
    S_DIV  = 14'b00000001000000,
    S_DFIN = 14'b00000010000000,
    S_SQRT = 14'b00000100000000,
    S_NORM = 14'b00001000000000,
    S_CORD = 14'b00010000000000,
    S_AFIN = 14'b00100000000000,
    S_WB   = 14'b01000000000000,
    S_OUT  = 14'b10000000000000
  } state_t;

  state_t state;

  logic [CW-1:0] cnt;
  logic [3:0]    mode_q;
  logic          binop;
  logic [2:0]    status;
  logic          sat;
  logic signed [31:0] top_r, top_i, xr, xi, yr, yi, res_r, res_i;
  logic signed [63:0] prod;
  logic signed [65:0] acc;
  logic [63:0]   den, rem;
  logic [31:0]   dq;
  logic          dneg, pneg;
  crpn_pkg::term_t tsel;
  logic [1:0]    pk;
  logic [5:0]    it;
  logic [PW-1:0] pw;
  logic signed [45:0] cx, cy;
  logic signed [33:0] cz;

  logic [4:0] depth_out;

  // input side
  logic [3:0]    in_mode;
  logic [CW-1:0] cnt_eff;
  logic          accept;

  assign in_mode  = s_tuser[3:0];
  assign cnt_eff  = s_tuser[4] ? '0 : cnt;
  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  // stack ram
  logic          ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [63:0]   ram_wdata, ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = AW'(cnt_eff);
    ram_wdata = s_tdata;
    if (state == S_WB) begin
      ram_we    = 1'b1;
      ram_waddr = binop ? AW'(cnt - CW'(2)) : AW'(cnt - CW'(1));
      ram_wdata = {res_i, res_r};
    end else if (accept && in_mode == crpn_pkg::MODE_PUSH
                 && cnt_eff < CW'(STACK_DEPTH)) begin
      ram_we = 1'b1;
    end
  end

  assign ram_raddr = AW'(cnt_eff - CW'(2));

  crpn_ram #(.WIDTH(64), .DEPTH(STACK_DEPTH)) u_stack (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // shared multiplier operand selection
  logic signed [31:0] mul_a, mul_b;
  logic               sub1;

  always_comb begin
    mul_a = xr;
    mul_b = yr;
    sub1  = 1'b0;
    case (tsel)
      crpn_pkg::T_DEN: begin
        mul_a = pk == 2'd0 ? yr : yi;
        mul_b = pk == 2'd0 ? yr : yi;
      end
      crpn_pkg::T_MRE: begin
        mul_a = pk == 2'd0 ? xr : xi;
        mul_b = pk == 2'd0 ? yr : yi;
        sub1  = 1'b1;
      end
      crpn_pkg::T_MIM: begin
        mul_a = pk == 2'd0 ? xr : xi;
        mul_b = pk == 2'd0 ? yi : yr;
      end
      crpn_pkg::T_DRE: begin
        mul_a = pk == 2'd0 ? xr : xi;
        mul_b = pk == 2'd0 ? yr : yi;
      end
      crpn_pkg::T_DIM: begin
        mul_a = pk == 2'd0 ? xi : xr;
        mul_b = pk == 2'd0 ? yr : yi;
        sub1  = 1'b1;
      end
      crpn_pkg::T_MOD: begin
        mul_a = pk == 2'd0 ? xr : xi;
        mul_b = pk == 2'd0 ? xr : xi;
      end
      default: begin
        mul_a = xr;
        mul_b = yr;
      end
    endcase
  end

  logic signed [65:0] prod_ext;
  assign prod_ext = {{2{prod[63]}}, prod};

  // result part finish: truncate toward zero and saturate
  logic        fneg;
  logic [65:0] mmag, fq, flim;
  logic [31:0] fval;
  logic signed [31:0] part_val;
  logic        part_sat;

  always_comb begin
    mmag     = acc[65] ? 66'(-acc) : 66'(acc);
    fneg     = (state == S_MFIN) ? acc[65] : dneg;
    fq       = (state == S_MFIN) ? (mmag >> FRAC_BITS) : {34'd0, dq};
    flim     = fneg ? 66'h80000000 : 66'h7fffffff;
    part_sat = fq > flim;
    fval     = part_sat ? flim[31:0] : fq[31:0];
    part_val = fneg ? -$signed(fval) : $signed(fval);
  end

  // divider prep
  logic [63:0] dmag, rem0;
  logic [31:0] dq0;
  assign dmag = acc[65] ? 64'(-acc) : 64'(acc);
  assign rem0 = dmag >> (32 - FRAC_BITS);
  assign dq0  = dmag[31:0] << FRAC_BITS;

  // divider step
  logic [64:0] drem2;
  logic        dge;
  assign drem2 = {rem, dq[31]};
  assign dge   = drem2 >= {1'b0, den};

  // square root step
  logic [35:0] srem2;
  logic [33:0] strial;
  logic        sge;
  logic [31:0] sroot;
  assign srem2  = {rem[33:0], den[63:62]};
  assign strial = {dq, 2'b01};
  assign sge    = srem2 >= {2'b00, strial};
  assign sroot  = {dq[30:0], sge};

  // add and sub
  logic signed [32:0] sum_r, sum_i;
  assign sum_r = (mode_q == crpn_pkg::MODE_SUB) ? ({xr[31], xr} - {yr[31], yr})
                                                : ({xr[31], xr} + {yr[31], yr});
  assign sum_i = (mode_q == crpn_pkg::MODE_SUB) ? ({xi[31], xi} - {yi[31], yi})
                                                : ({xi[31], xi} + {yi[31], yi});

  function automatic logic signed [31:0] clip32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v > 33'sh07fffffff)      r = 32'sh7fffffff;
    else if (v < -33'sh080000000) r = 32'sh80000000;
    else                          r = v[31:0];
    return r;
  endfunction

  // power step count
  logic [32:0]   ymag, nfull;
  logic [PW-1:0] npow;
  assign ymag  = yr[31] ? 33'(-$signed({yr[31], yr})) : {1'b0, yr};
  assign nfull = (ymag + NROUND) >> FRAC_BITS;
  assign npow  = (nfull > 33'(MAX_POWER)) ? PW'(MAX_POWER) : PW'(nfull);

  // cordic
  logic signed [45:0] xs, ys;
  logic signed [33:0] zstep;
  logic               norm_go;
  logic [33:0]        zmag, zrnd;
  assign xs      = cy >>> it[4:0];
  assign ys      = cx >>> it[4:0];
  assign zstep   = $signed({4'd0, crpn_pkg::atan_q30(it[4:0])});
  assign norm_go = (cx < LIM40) && (cx > -LIM40) && (cy < LIM40) && (cy > -LIM40);
  assign zmag    = cz[33] ? 34'(-cz) : 34'(cz);
  assign zrnd    = (zmag + (34'd1 << (ASH - 1))) >> ASH;

  assign depth_out = 5'(cnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      cnt      <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_OUT) begin
        m_tvalid <= 1'b0;
      end
      prod <= mul_a * mul_b;
      case (state)
        S_IDLE: begin
          if (accept) begin
            mode_q <= in_mode;
            status <= crpn_pkg::ST_OK;
            sat    <= 1'b0;
            cnt    <= cnt_eff;
            binop  <= 1'b0;
            state  <= S_OUT;
            case (in_mode)
              crpn_pkg::MODE_PUSH: begin
                if (cnt_eff >= CW'(STACK_DEPTH)) begin
                  status <= crpn_pkg::ST_OVER;
                end else begin
                  top_r <= s_tdata[31:0];
                  top_i <= s_tdata[63:32];
                  cnt   <= cnt_eff + CW'(1);
                end
              end
              crpn_pkg::MODE_ADD, crpn_pkg::MODE_SUB, crpn_pkg::MODE_MUL,
              crpn_pkg::MODE_DIV, crpn_pkg::MODE_POW: begin
                if (cnt_eff < CW'(2)) begin
                  status <= crpn_pkg::ST_UNDER;
                end else begin
                  yr    <= top_r;
                  yi    <= top_i;
                  binop <= 1'b1;
                  state <= S_RDA;
                end
              end
              crpn_pkg::MODE_ARG, crpn_pkg::MODE_CONJ, crpn_pkg::MODE_MOD: begin
                if (cnt_eff == '0) begin
                  status <= crpn_pkg::ST_UNDER;
                end else begin
                  xr    <= top_r;
                  xi    <= top_i;
                  state <= S_EXEC;
                end
              end
              default: state <= S_OUT;
            endcase
          end
        end
        S_RDA: begin
          xr    <= ram_rdata[31:0];
          xi    <= ram_rdata[63:32];
          state <= S_EXEC;
        end
        S_EXEC: begin
          pk <= 2'd0;
          case (mode_q)
            crpn_pkg::MODE_ADD, crpn_pkg::MODE_SUB: begin
              res_r <= clip32(sum_r);
              res_i <= clip32(sum_i);
              if (clip32(sum_r) != sum_r[31:0] || sum_r[32] != sum_r[31]
                  || sum_i[32] != sum_i[31]) begin
                sat <= 1'b1;
              end
              state <= S_WB;
            end
            crpn_pkg::MODE_MUL: begin
              tsel  <= crpn_pkg::T_MRE;
              state <= S_PROD;
            end
            crpn_pkg::MODE_DIV: begin
              tsel  <= crpn_pkg::T_DEN;
              state <= S_PROD;
            end
            crpn_pkg::MODE_POW: begin
              if (yi != '0) begin
                status <= crpn_pkg::ST_EXPC;
                state  <= S_OUT;
              end else if (yr[31] && xr == '0 && xi == '0) begin
                status <= crpn_pkg::ST_DIVZ;
                state  <= S_OUT;
              end else begin
                yr    <= xr;
                yi    <= xi;
                xr    <= ONE_Q;
                xi    <= '0;
                pw    <= npow;
                pneg  <= yr[31];
                tsel  <= yr[31] ? crpn_pkg::T_DEN : crpn_pkg::T_MRE;
                if (npow == '0) begin
                  res_r <= ONE_Q;
                  res_i <= '0;
                  state <= S_WB;
                end else begin
                  state <= S_PROD;
                end
              end
            end
            crpn_pkg::MODE_ARG: begin
              if (xr == '0 && xi == '0) begin
                res_r <= '0;
                res_i <= '0;
                state <= S_WB;
              end else begin
                cx    <= 46'(xr);
                cy    <= 46'(xi);
                cz    <= '0;
                state <= S_NORM;
              end
            end
            crpn_pkg::MODE_CONJ: begin
              res_r <= xr;
              if (xi == 32'sh80000000) begin
                res_i <= 32'sh7fffffff;
                sat   <= 1'b1;
              end else begin
                res_i <= -xi;
              end
              state <= S_WB;
            end
            crpn_pkg::MODE_MOD: begin
              tsel  <= crpn_pkg::T_MOD;
              state <= S_PROD;
            end
            default: state <= S_OUT;
          endcase
        end
        S_PROD: begin
          pk <= pk + 2'd1;
          if (pk == 2'd1) begin
            acc <= prod_ext;
          end else if (pk == 2'd2) begin
            acc <= sub1 ? acc - prod_ext : acc + prod_ext;
          end else if (pk == 2'd3) begin
            case (tsel)
              crpn_pkg::T_DEN: begin
                den <= acc[63:0];
                pk  <= 2'd0;
                if (acc == '0) begin
                  status <= crpn_pkg::ST_DIVZ;
                  state  <= S_OUT;
                end else begin
                  tsel <= crpn_pkg::T_DRE;
                end
              end
              crpn_pkg::T_MRE, crpn_pkg::T_MIM: state <= S_MFIN;
              crpn_pkg::T_DRE, crpn_pkg::T_DIM: state <= S_DPRE;
              default: begin
                den   <= acc[63:0];
                rem   <= '0;
                dq    <= '0;
                it    <= '0;
                state <= S_SQRT;
              end
            endcase
          end
        end
        S_DPRE: begin
          dneg <= acc[65];
          it   <= '0;
          if (rem0 >= den) begin
            dq    <= '1;
            state <= S_DFIN;
          end else begin
            rem   <= rem0;
            dq    <= dq0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= dge ? 64'(drem2 - {1'b0, den}) : drem2[63:0];
          dq  <= {dq[30:0], dge};
          it  <= it + 6'd1;
          if (it == 6'd31) begin
            state <= S_DFIN;
          end
        end
        S_MFIN, S_DFIN: begin
          pk <= 2'd0;
          if (part_sat) begin
            sat <= 1'b1;
          end
          if (tsel == crpn_pkg::T_MRE || tsel == crpn_pkg::T_DRE) begin
            res_r <= part_val;
            tsel  <= (tsel == crpn_pkg::T_MRE) ? crpn_pkg::T_MIM : crpn_pkg::T_DIM;
            state <= S_PROD;
          end else if (mode_q == crpn_pkg::MODE_POW && pw != PW'(1)) begin
            // next power step uses the running value as the left operand
            pw    <= pw - PW'(1);
            xr    <= res_r;
            xi    <= part_val;
            tsel  <= pneg ? crpn_pkg::T_DRE : crpn_pkg::T_MRE;
            state <= S_PROD;
          end else begin
            res_i <= part_val;
            state <= S_WB;
          end
        end
        S_SQRT: begin
          rem <= sge ? 64'(srem2 - {2'b00, strial}) : 64'(srem2);
          dq  <= sroot;
          den <= den << 2;
          it  <= it + 6'd1;
          if (it == 6'd31) begin
            res_i <= '0;
            if (sroot[31]) begin
              res_r <= 32'sh7fffffff;
              sat   <= 1'b1;
            end else begin
              res_r <= $signed(sroot);
            end
            state <= S_WB;
          end
        end
        S_NORM: begin
          it <= '0;
          if (norm_go) begin
            cx <= cx <<< 1;
            cy <= cy <<< 1;
          end else begin
            // fold left half plane into the right one
            if (cx < 0) begin
              if (cy >= 0) begin
                cx <= cy;
                cy <= -cx;
                cz <= crpn_pkg::HALF_PI_Q30;
              end else begin
                cx <= -cy;
                cy <= cx;
                cz <= -crpn_pkg::HALF_PI_Q30;
              end
            end
            state <= S_CORD;
          end
        end
        S_CORD: begin
          if (cy > 0) begin
            cx <= cx + xs;
            cy <= cy - ys;
            cz <= cz + zstep;
          end else begin
            cx <= cx - xs;
            cy <= cy + ys;
            cz <= cz - zstep;
          end
          it <= it + 6'd1;
          if (it == 6'd29) begin
            state <= S_AFIN;
          end
        end
        S_AFIN: begin
          res_r <= cz[33] ? -$signed(32'(zrnd)) : $signed(32'(zrnd));
          res_i <= '0;
          state <= S_WB;
        end
        S_WB: begin
          top_r <= res_r;
          top_i <= res_i;
          if (binop) begin
            cnt <= cnt - CW'(1);
          end
          state <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {3'b000, depth_out,
                         (cnt == '0) ? 32'd0 : top_i,
                         (cnt == '0) ? 32'd0 : top_r};
            m_tuser  <= (status == crpn_pkg::ST_OK && sat) ? crpn_pkg::ST_SAT : status;
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(STACK_DEPTH))
    else $error("stack count beyond depth");

  a_wb_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_WB |-> cnt != '0)
    else $error("write back on empty stack");

  a_over_full: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == crpn_pkg::ST_OVER) |-> m_tdata[68:64] == 5'(STACK_DEPTH))
    else $error("overflow reported on a stack that is not full");

  a_under_shallow: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser == crpn_pkg::ST_UNDER) |-> m_tdata[68:64] < 5'd2)
    else $error("underflow reported with two or more entries");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && m_tvalid && !m_tready) |=> state == S_OUT)
    else $error("result lost while output stalled");

endmodule
